// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the event queue core.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`endif
`endif

// ----- hw/rtl/tevq_pkg.sv -----
// Shared codes and field widths of the timed event queue.
// No dependencies.
`default_nettype none
package tevq_pkg;
   localparam int KindW = 2;
   localparam int TimeW = 32;
   localparam int ObjPortW = 16;
   localparam int UserW = 32;
   localparam int StatusW = 3;
   localparam int MaxFire = 16;
   localparam int FireW = 5;

   localparam logic [KindW-1:0] KIND_ADD = 2'd0;
   localparam logic [KindW-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KindW-1:0] KIND_FIND = 2'd2;
   localparam logic [KindW-1:0] KIND_ACTIVATE = 2'd3;

   localparam logic [StatusW-1:0] ST_ADDED = 3'd0;
   localparam logic [StatusW-1:0] ST_FULL = 3'd1;
   localparam logic [StatusW-1:0] ST_FOUND = 3'd2;
   localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [StatusW-1:0] ST_FIRED = 3'd4;
   localparam logic [StatusW-1:0] ST_NONE = 3'd5;

   // Status the back end reports to the top level.
   typedef struct packed {
      logic [8:0] count;
      logic       busy;
   } back_status_type;
endpackage
`default_nettype wire

// ----- hw/rtl/timed_event_queue_core.sv -----
// Timed event queue core: a time-sorted queue of pending events.
// Depends on tevq_pkg, tevq_front, tevq_back and assert_macros.svh.
//
// Usage:
//   The req channel carries one command per transaction: tuser holds the
//   kind (add, remove, find, activate), tdata the time, object, user word
//   and current time. The rsp channel returns results; tlast marks the last
//   result caused by a command. Add, remove and find give one result each;
//   activate gives one result per fired entry (at most 16) or one
//   nothing-due result.
//   Path: a command is registered in the two-entry front queue and is then
//   executed by the back end, which registers its result in the result
//   register. Activate gives its fired entries one at a time through the
//   single pop port of the cell row. Sustained rate is one command per cycle
//   for single results while the receiver takes every result.
//   Reset empties the queue and both channels. When the receiver stalls the
//   result register holds, the back end waits, and the front queue keeps
//   taking commands until its two entries are full.
`default_nettype none
`include "assert_macros.svh"
module timed_event_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int OBJECT_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // event_time[31:0], object_id[47:32], user_word[79:48], now_time[111:80]
   input  wire logic [111:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[2:0], fired_object[18:3], fired_user_word[50:19], zero fill above
   output logic [55:0]       rsp_tdata,
   output logic              rsp_tlast
);
   localparam int CMD_W = tevq_pkg::KindW + 3 * tevq_pkg::TimeW + OBJECT_BITS;

   logic [CMD_W-1:0] in_cmd, cmd_data;
   logic             cmd_valid, cmd_ready;
   logic [1:0]       fill;
   logic [31:0]      obj_wide;
   logic [tevq_pkg::StatusW-1:0] st;
   logic [tevq_pkg::ObjPortW-1:0] ob;
   logic [tevq_pkg::UserW-1:0]   uw;
   tevq_pkg::back_status_type    bstat;

   // Pack the command with the object id cut to the stored width.
   assign obj_wide = {16'b0, req_tdata[47:32]};
   assign in_cmd = {req_tdata[111:80], req_tdata[79:48],
                    obj_wide[OBJECT_BITS-1:0], req_tdata[31:0], req_tuser};

   tevq_front #(.CMD_W(CMD_W)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
      .fill(fill)
   );

   tevq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .OBJECT_BITS(OBJECT_BITS),
               .CMD_W(CMD_W)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_status(st), .out_object(ob), .out_user(uw), .out_last(rsp_tlast),
      .status(bstat)
   );

   assign rsp_tdata = {5'b0, uw, ob, st};

   // Checks on the queue occupancy and result framing.
   `ASSERT_ALWAYS(a_count_max, clock, reset, bstat.count <= 9'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_fill_max, clock, reset, fill <= 2'd2)
   `ASSERT_IMPLIES(a_single_last, clock, reset,
      rsp_tvalid && (st != tevq_pkg::ST_FIRED), rsp_tlast)
   `ASSERT_IMPLIES(a_fire_busy, clock, reset,
      rsp_tvalid && !rsp_tlast, bstat.busy || $past(bstat.busy) || st == tevq_pkg::ST_FIRED)
endmodule
`default_nettype wire

// ----- hw/rtl/tevq_front.sv -----
// Front end: accepts request transactions and holds them in a two-entry queue.
// Depends on no other file.
`default_nettype none
module tevq_front #(
   parameter int CMD_W = 114
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [CMD_W-1:0] in_cmd,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output logic [CMD_W-1:0]      cmd_data,
   output logic [1:0]            fill
);
   logic [CMD_W-1:0] slot_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   // Queue control.
   always_comb begin
      in_ready = (count_ff != 2'd2);
      cmd_valid = (count_ff != 2'd0);
      cmd_data = slot_ff[rd_ff];
      push = in_valid && in_ready;
      pop = cmd_valid && cmd_ready;
      wr_in = wr_ff ^ push;
      rd_in = rd_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      fill = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_cmd;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/tevq_back.sv -----
// Back end: the sorted cell row, its sequencer and the result register.
// Depends on tevq_pkg.
`default_nettype none
module tevq_back #(
   parameter int QUEUE_DEPTH = 16,
   parameter int OBJECT_BITS = 16,
   parameter int CMD_W = 114
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        cmd_valid,
   output logic                             cmd_ready,
   input  wire logic [CMD_W-1:0]            cmd_data,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [tevq_pkg::StatusW-1:0]     out_status,
   output logic [tevq_pkg::ObjPortW-1:0]    out_object,
   output logic [tevq_pkg::UserW-1:0]       out_user,
   output logic                             out_last,
   output tevq_pkg::back_status_type        status
);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic S_IDLE = 1'b0;
   localparam logic S_FIRE = 1'b1;
   localparam int OT = tevq_pkg::KindW + tevq_pkg::TimeW;
   localparam int UT = OT + OBJECT_BITS;
   localparam int NT = UT + tevq_pkg::UserW;

   logic [tevq_pkg::TimeW-1:0] time_ff [QUEUE_DEPTH];
   logic [tevq_pkg::TimeW-1:0] time_in [QUEUE_DEPTH];
   logic [OBJECT_BITS-1:0]     obj_ff [QUEUE_DEPTH];
   logic [OBJECT_BITS-1:0]     obj_in [QUEUE_DEPTH];
   logic [tevq_pkg::UserW-1:0] user_ff [QUEUE_DEPTH];
   logic [tevq_pkg::UserW-1:0] user_in [QUEUE_DEPTH];
   logic [CW-1:0]              count_ff, count_in;
   logic                       state_ff, state_in;
   logic [tevq_pkg::FireW-1:0] fired_ff, fired_in;
   logic [tevq_pkg::TimeW-1:0] now_ff, now_in;

   logic                         rv_ff, rv_in;
   logic [tevq_pkg::StatusW-1:0] rs_ff, rs_in;
   logic [tevq_pkg::ObjPortW-1:0] ro_ff, ro_in;
   logic [tevq_pkg::UserW-1:0]   ru_ff, ru_in;
   logic                         rl_ff, rl_in;

   logic [tevq_pkg::KindW-1:0] c_kind;
   logic [tevq_pkg::TimeW-1:0] c_time, c_now, a_now;
   logic [OBJECT_BITS-1:0]     c_obj;
   logic [tevq_pkg::UserW-1:0] c_user;
   logic [tevq_pkg::FireW-1:0] a_fired;
   logic [QUEUE_DEPTH-1:0]     later, match, seen;
   logic                       out_free, due0, due1, more, load;
   logic [31:0]                obj_wide;

   assign c_kind = cmd_data[tevq_pkg::KindW-1:0];
   assign c_time = cmd_data[OT-1:tevq_pkg::KindW];
   assign c_obj = cmd_data[UT-1:OT];
   assign c_user = cmd_data[NT-1:UT];
   assign c_now = cmd_data[CMD_W-1:NT];

   // Per-cell compares and the prefix of remove matches.
   always_comb begin
      logic acc;
      acc = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         later[i] = (i < int'(count_ff)) && (c_time < time_ff[i]);
         match[i] = (i < int'(count_ff)) && (obj_ff[i] == c_obj);
         acc = acc | match[i];
         seen[i] = acc;
      end
   end

   // Activate step: is the front due, and will the one after it fire too.
   always_comb begin
      a_now = (state_ff == S_IDLE) ? c_now : now_ff;
      a_fired = (state_ff == S_IDLE) ? '0 : fired_ff;
      due0 = (count_ff != '0) && !(a_now < time_ff[0]);
      due1 = (count_ff > CW'(1)) && !(a_now < time_ff[1 % QUEUE_DEPTH]);
      more = due1 && ((a_fired + 1'b1) < tevq_pkg::FireW'(tevq_pkg::MaxFire));
      obj_wide = 32'(obj_ff[0]);
   end

   // Sequencer and cell updates.
   always_comb begin
      time_in = time_ff;
      obj_in = obj_ff;
      user_in = user_ff;
      count_in = count_ff;
      state_in = state_ff;
      fired_in = fired_ff;
      now_in = now_ff;
      cmd_ready = 1'b0;
      load = 1'b0;
      rs_in = tevq_pkg::ST_NONE;
      ro_in = '0;
      ru_in = '0;
      rl_in = 1'b1;
      out_free = !rv_ff || out_ready;

      if (out_free && ((state_ff == S_FIRE) || (cmd_valid &&
          (c_kind == tevq_pkg::KIND_ACTIVATE)))) begin
         // One activate step: pop the front if due.
         cmd_ready = (state_ff == S_IDLE);
         now_in = a_now;
         load = 1'b1;
         if (due0) begin
            rs_in = tevq_pkg::ST_FIRED;
            ro_in = obj_wide[tevq_pkg::ObjPortW-1:0];
            ru_in = user_ff[0];
            rl_in = !more;
            for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
               time_in[i] = time_ff[i+1];
               obj_in[i] = obj_ff[i+1];
               user_in[i] = user_ff[i+1];
            end
            count_in = count_ff - 1'b1;
            fired_in = a_fired + 1'b1;
            state_in = more ? S_FIRE : S_IDLE;
         end else begin
            state_in = S_IDLE;
         end
      end else if (out_free && (state_ff == S_IDLE) && cmd_valid) begin
         cmd_ready = 1'b1;
         load = 1'b1;
         case (c_kind)
            tevq_pkg::KIND_ADD: begin
               if (count_ff == CW'(QUEUE_DEPTH)) begin
                  rs_in = tevq_pkg::ST_FULL;
               end else begin
                  rs_in = tevq_pkg::ST_ADDED;
                  for (int i = 0; i < QUEUE_DEPTH; i++) begin
                     if (i > 0 && later[(i > 0) ? i - 1 : 0]) begin
                        time_in[i] = time_ff[(i > 0) ? i - 1 : 0];
                        obj_in[i] = obj_ff[(i > 0) ? i - 1 : 0];
                        user_in[i] = user_ff[(i > 0) ? i - 1 : 0];
                     end else if (later[i] || (i == int'(count_ff))) begin
                        time_in[i] = c_time;
                        obj_in[i] = c_obj;
                        user_in[i] = c_user;
                     end
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            tevq_pkg::KIND_REMOVE: begin
               if (seen[QUEUE_DEPTH-1]) begin
                  rs_in = tevq_pkg::ST_FOUND;
                  for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
                     if (seen[i]) begin
                        time_in[i] = time_ff[i+1];
                        obj_in[i] = obj_ff[i+1];
                        user_in[i] = user_ff[i+1];
                     end
                  end
                  count_in = count_ff - 1'b1;
               end else begin
                  rs_in = tevq_pkg::ST_NOTFOUND;
               end
            end
            tevq_pkg::KIND_FIND: begin
               rs_in = seen[QUEUE_DEPTH-1] ? tevq_pkg::ST_FOUND
                                           : tevq_pkg::ST_NOTFOUND;
            end
            default: begin
               rs_in = tevq_pkg::ST_NONE;
            end
         endcase
      end

      // Result register: load a new result or drop the one taken.
      if (load) begin
         rv_in = 1'b1;
      end else begin
         rv_in = rv_ff && !out_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         state_ff <= S_IDLE;
         fired_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         state_ff <= state_in;
         fired_ff <= fired_in;
         rv_ff <= rv_in;
      end
   end

   // Cell payload and result payload.
   always_ff @(posedge clock) begin
      time_ff <= time_in;
      obj_ff <= obj_in;
      user_ff <= user_in;
      now_ff <= now_in;
      if (load) begin
         rs_ff <= rs_in;
         ro_ff <= ro_in;
         ru_ff <= ru_in;
         rl_ff <= rl_in;
      end
   end

   assign out_valid = rv_ff;
   assign out_status = rs_ff;
   assign out_object = ro_ff;
   assign out_user = ru_ff;
   assign out_last = rl_ff;
   assign status.count = 9'(count_ff);
   assign status.busy = (state_ff == S_FIRE);
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for timed_event_queue_core: drives commands on the req stream,
// predicts results with a local model of the sorted event store, checks the rsp stream.
// Depends on tevq_pkg and the RTL of timed_event_queue_core.
`default_nettype none
module testbench;
   localparam int Depth = 16;
   localparam int WatchdogLimit = 20000;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] fired_object;
      logic [31:0] fired_user_word;
      logic        last;
   } outcome_type;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] event_time;
      logic [15:0] object_id;
      logic [31:0] user_word;
      logic [31:0] now_time;
      logic        checked;
      logic [2:0]  status;
   } command_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [55:0]   rsp_tdata;
   logic          rsp_tlast;

   timed_event_queue_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the sorted event store.
   logic [31:0] shadow_time[Depth];
   logic [15:0] shadow_object[Depth];
   logic [31:0] shadow_user[Depth];
   int          shadow_count = 0;

   outcome_type pending_results[$];
   command_type directed_rows[$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          fired_count = 0;
   int          full_count = 0;
   int          accept_count = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          timed_out = 1'b0;

   function automatic outcome_type single_result(logic [2:0] status);
      outcome_type r;
      r = '0;
      r.status = status;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic int find_object(logic [15:0] object_id);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_object[i] == object_id) return i;
      return -1;
   endfunction

   function automatic void drop_entry(int pos);
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_time[i] = shadow_time[i+1];
         shadow_object[i] = shadow_object[i+1];
         shadow_user[i] = shadow_user[i+1];
      end
      shadow_count--;
   endfunction

   // Apply one command to the shadow store and queue the results it causes.
   function automatic void predict_queue(command_type c);
      int pos;
      int fired;
      outcome_type r;
      case (c.kind)
         tevq_pkg::KIND_ADD: begin
            if (shadow_count >= Depth) begin
               pending_results.push_back(single_result(tevq_pkg::ST_FULL));
            end else begin
               pos = shadow_count;
               while (pos > 0 && c.event_time < shadow_time[pos-1]) pos--;
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_time[i] = shadow_time[i-1];
                  shadow_object[i] = shadow_object[i-1];
                  shadow_user[i] = shadow_user[i-1];
               end
               shadow_time[pos] = c.event_time;
               shadow_object[pos] = c.object_id;
               shadow_user[pos] = c.user_word;
               shadow_count++;
               pending_results.push_back(single_result(tevq_pkg::ST_ADDED));
            end
         end
         tevq_pkg::KIND_REMOVE: begin
            pos = find_object(c.object_id);
            if (pos < 0) begin
               pending_results.push_back(single_result(tevq_pkg::ST_NOTFOUND));
            end else begin
               drop_entry(pos);
               pending_results.push_back(single_result(tevq_pkg::ST_FOUND));
            end
         end
         tevq_pkg::KIND_FIND: begin
            pending_results.push_back(single_result(find_object(c.object_id) < 0 ?
               tevq_pkg::ST_NOTFOUND : tevq_pkg::ST_FOUND));
         end
         default: begin
            fired = 0;
            while (fired < tevq_pkg::MaxFire && shadow_count > 0 &&
                   !(c.now_time < shadow_time[0])) begin
               r.status = tevq_pkg::ST_FIRED;
               r.fired_object = shadow_object[0];
               r.fired_user_word = shadow_user[0];
               r.last = 1'b0;
               pending_results.push_back(r);
               drop_entry(0);
               fired++;
            end
            if (fired == 0) pending_results.push_back(single_result(tevq_pkg::ST_NONE));
            else pending_results[$].last = 1'b1;
         end
      endcase
   endfunction

   // Result side: compare each transaction with the oldest expectation.
   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[2:0];
         got.fired_object = rsp_tdata[18:3];
         got.fired_user_word = rsp_tdata[50:19];
         got.last = rsp_tlast;
         result_count++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result status=%0d obj=%h user=%h last=%b",
                        got.status, got.fired_object, got.fired_user_word, got.last);
         end else begin
            want = pending_results.pop_front();
            if (got.status == tevq_pkg::ST_FIRED) fired_count++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: result %0d expected %0d/%h/%h/%b got %0d/%h/%h/%b",
                           result_count, want.status, want.fired_object,
                           want.fired_user_word, want.last, got.status,
                           got.fired_object, got.fired_user_word, got.last);
            end
         end
      end
   end

   // Receiver stalls, decided at the falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("timed_event_queue_core test failed");
            $finish;
         end
      end
   end

   // Status a typed-in row should give, read from the shadow store before it updates.
   function automatic logic [2:0] pending_expected_status(command_type c);
      if (c.kind == tevq_pkg::KIND_ADD)
         return shadow_count >= Depth ? tevq_pkg::ST_FULL : tevq_pkg::ST_ADDED;
      if (c.kind == tevq_pkg::KIND_ACTIVATE)
         return shadow_count == 0 ? tevq_pkg::ST_NONE : tevq_pkg::ST_FIRED;
      return find_object(c.object_id) < 0 ? tevq_pkg::ST_NOTFOUND : tevq_pkg::ST_FOUND;
   endfunction

   // Drive one command at the falling edge and hold it until accepted.
   task automatic send_command(command_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= c.kind;
      req_tdata <= {c.now_time, c.user_word, c.object_id, c.event_time};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accept_count++;
      predict_queue(c);
      @(negedge clock);
   endtask

   function automatic command_type make_row(logic [1:0] kind, logic [31:0] t,
                                            logic [15:0] obj, logic [31:0] uw,
                                            logic [31:0] now, logic checked,
                                            logic [2:0] status);
      command_type c;
      c.kind = kind; c.event_time = t; c.object_id = obj;
      c.user_word = uw; c.now_time = now; c.checked = checked; c.status = status;
      return c;
   endfunction

   // Random command, mostly adds and activates on a narrow time window.
   function automatic command_type random_command(logic [31:0] base);
      command_type c;
      int pick;
      pick = $urandom_range(99);
      c.kind = pick < 45 ? tevq_pkg::KIND_ADD : pick < 60 ? tevq_pkg::KIND_REMOVE :
               pick < 72 ? tevq_pkg::KIND_FIND : tevq_pkg::KIND_ACTIVATE;
      c.event_time = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(200);
      c.object_id = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(15));
      if (pick >= 45 && pick < 72 && shadow_count > 0 && $urandom_range(1))
         c.object_id = shadow_object[$urandom_range(shadow_count - 1)];
      c.user_word = $urandom;
      c.now_time = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(200);
      c.checked = 1'b0;
      c.status = '0;
      return c;
   endfunction

   // Stop sending and wait until every expected result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      command_type c;
      int row_errors;
      row_errors = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: extremes of each field, every kind, empty and full cases.
      directed_rows.push_back(make_row(tevq_pkg::KIND_ACTIVATE, '0, '0, '0, 32'hFFFF_FFFF,
                                       1'b1, tevq_pkg::ST_NONE));
      directed_rows.push_back(make_row(tevq_pkg::KIND_FIND, '0, 16'hFFFF, '0, '0, 1'b1,
                                       tevq_pkg::ST_NOTFOUND));
      directed_rows.push_back(make_row(tevq_pkg::KIND_REMOVE, '0, 16'h0000, '0, '0, 1'b1,
                                       tevq_pkg::ST_NOTFOUND));
      directed_rows.push_back(make_row(tevq_pkg::KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF,
                                       32'hFFFF_FFFF, '0, 1'b1, tevq_pkg::ST_ADDED));
      directed_rows.push_back(make_row(tevq_pkg::KIND_ADD, '0, 16'h0000, 32'h0,
                                       32'hFFFF_FFFF, 1'b1, tevq_pkg::ST_ADDED));
      directed_rows.push_back(make_row(tevq_pkg::KIND_ADD, 32'd100, 16'h1234, 32'hA5A5_5A5A,
                                       '0, 1'b1, tevq_pkg::ST_ADDED));
      directed_rows.push_back(make_row(tevq_pkg::KIND_ADD, 32'd100, 16'h4321, 32'h5A5A_A5A5,
                                       '0, 1'b1, tevq_pkg::ST_ADDED));
      directed_rows.push_back(make_row(tevq_pkg::KIND_FIND, '0, 16'h1234, '0, '0, 1'b1,
                                       tevq_pkg::ST_FOUND));
      directed_rows.push_back(make_row(tevq_pkg::KIND_REMOVE, '0, 16'h4321, '0, '0, 1'b1,
                                       tevq_pkg::ST_FOUND));
      directed_rows.push_back(make_row(tevq_pkg::KIND_ACTIVATE, '0, '0, '0, 32'd99, 1'b0,
                                       '0));
      directed_rows.push_back(make_row(tevq_pkg::KIND_ACTIVATE, '0, '0, '0, 32'd100, 1'b0,
                                       '0));
      // One entry is left here; fifteen more fill the store.
      for (int i = 0; i < 15; i++)
         directed_rows.push_back(make_row(tevq_pkg::KIND_ADD, 32'(50 - i), 16'(i + 2),
                                          32'(i * 7), '0, 1'b0, '0));
      directed_rows.push_back(make_row(tevq_pkg::KIND_ADD, 32'd5, 16'h7777, 32'd1, '0,
                                       1'b1, tevq_pkg::ST_FULL));
      directed_rows.push_back(make_row(tevq_pkg::KIND_ACTIVATE, '0, '0, '0, 32'hFFFF_FFFE,
                                       1'b0, '0));

      foreach (directed_rows[i]) begin
         c = directed_rows[i];
         if (c.checked && c.status != pending_expected_status(c)) begin
            row_errors++;
            $display("ERROR: directed row %0d expected status %0d, model gives %0d",
                     i, c.status, pending_expected_status(c));
         end
         send_command(c);
      end
      drain_results();
      mismatch_count += row_errors;

      // Random part over the four idling phases.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 62 : 14) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 62 : 14) : 0;
         for (int n = 0; n < 45; n++) begin
            send_command(random_command(32'(phase * 1000 + n * 4)));
            // Hold off once per phase until everything outstanding has come back.
            if (n == 22) drain_results();
         end
         send_command(make_row(tevq_pkg::KIND_ACTIVATE, '0, '0, '0, 32'hFFFF_FFFF, 1'b0,
                               '0));
      end
      drain_results();

      $display("Ran %0d commands, checked %0d results with %0d fired events.",
               accept_count, result_count, fired_count);
      $display("Covered empty and full store, every kind, and all idle and stall phases.");
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("timed_event_queue_core test passed");
      end else begin
         $display("timed_event_queue_core test failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- timed_event_queue_core.f -----
+incdir+hw/rtl
hw/rtl/tevq_pkg.sv
hw/rtl/tevq_front.sv
hw/rtl/tevq_back.sv
hw/rtl/timed_event_queue_core.sv
dv/testbench.sv
